// ===== hdl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);

    localparam logic [2:0] ST_FREE    = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_WAITING = 3'd3;
    localparam logic [2:0] ST_ZOMBIE  = 3'd4;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_SCHED  = 2'd1;
    localparam logic [1:0] ACT_EXIT   = 2'd2;
    localparam logic [1:0] ACT_WAIT   = 2'd3;

    localparam logic [2:0] RC_OK      = 3'd0;
    localparam logic [2:0] RC_NOTHING = 3'd1;
    localparam logic [2:0] RC_FULL    = 3'd2;
    localparam logic [2:0] RC_UNSUPP  = 3'd3;
    localparam logic [2:0] RC_KERNEL  = 3'd4;
    localparam logic [2:0] RC_BLOCKED = 3'd5;

    localparam logic [1:0] SCAN_FREE   = 2'd0;
    localparam logic [1:0] SCAN_READY  = 2'd1;
    localparam logic [1:0] SCAN_WAITER = 2'd2;
    localparam logic [1:0] SCAN_ZOMBIE = 2'd3;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_SCAN      = 4'd1;
    localparam logic [3:0] OP_SETRC     = 4'd2;
    localparam logic [3:0] OP_CREATE    = 4'd3;
    localparam logic [3:0] OP_RUN       = 4'd4;
    localparam logic [3:0] OP_RUN_SCHED = 4'd5;
    localparam logic [3:0] OP_ZOMBIE    = 4'd6;
    localparam logic [3:0] OP_WAKE      = 4'd7;
    localparam logic [3:0] OP_REAP      = 4'd8;
    localparam logic [3:0] OP_BLOCK     = 4'd9;

    localparam logic [14:0] PID_MAX = 15'd32767;

    typedef struct packed {
        logic             latch;
        logic [3:0]       op;
        logic [1:0]       kind;
        logic [IDX_W-1:0] idx;
        logic [2:0]       rc;
        logic             out_load;
    } pts_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       stalled;
        logic       kernel;
        logic       target_bad;
        logic       no_hang;
        logic       found;
        logic       out_free;
    } pts_sts_t;

endpackage

// ===== hdl/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: steps each action through table scans and update operations, or ends it early with a result code.
// ----------------------------------------------------------------------------
module pts_ctrl
    import pts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  pts_sts_t sts,
    output pts_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_C_SCAN   = 4'd2;
    localparam logic [3:0] S_C_APPLY  = 4'd3;
    localparam logic [3:0] S_Y_SCAN   = 4'd4;
    localparam logic [3:0] S_Y_RUN    = 4'd5;
    localparam logic [3:0] S_E_ZOMB   = 4'd6;
    localparam logic [3:0] S_E_SCANW  = 4'd7;
    localparam logic [3:0] S_E_WAKE   = 4'd8;
    localparam logic [3:0] S_R_SCAN   = 4'd9;
    localparam logic [3:0] S_R_RUN    = 4'd10;
    localparam logic [3:0] S_W_SCANZ  = 4'd11;
    localparam logic [3:0] S_W_DECIDE = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TASKS - 1);

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last;

    assign last     = (idx_reg == IDX_LAST);
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = '0;
        cmd.latch    = 1'b0;
        cmd.op       = OP_NONE;
        cmd.kind     = SCAN_FREE;
        cmd.idx      = idx_reg;
        cmd.rc       = RC_OK;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.action)
                    ACT_CREATE: state_next = S_C_SCAN;
                    ACT_SCHED:  state_next = S_Y_SCAN;
                    ACT_EXIT:
                    begin
                        if (sts.kernel)
                        begin
                            cmd.op = OP_SETRC; cmd.rc = RC_KERNEL; state_next = S_OUT;
                        end
                        else if (sts.stalled)
                        begin
                            cmd.op = OP_SETRC; cmd.rc = RC_NOTHING; state_next = S_OUT;
                        end
                        else
                            state_next = S_E_ZOMB;
                    end
                    default:
                    begin
                        if (sts.target_bad)
                        begin
                            cmd.op = OP_SETRC; cmd.rc = RC_UNSUPP; state_next = S_OUT;
                        end
                        else if (sts.stalled)
                        begin
                            cmd.op = OP_SETRC; cmd.rc = RC_NOTHING; state_next = S_OUT;
                        end
                        else
                            state_next = S_W_SCANZ;
                    end
                endcase
            end
            S_C_SCAN:
            begin
                cmd.op = OP_SCAN; cmd.kind = SCAN_FREE;
                idx_next = idx_reg + 1'b1;
                if (last) state_next = S_C_APPLY;
            end
            S_C_APPLY:
            begin
                cmd.op = OP_CREATE; state_next = S_OUT;
            end
            S_Y_SCAN:
            begin
                cmd.op = OP_SCAN; cmd.kind = SCAN_READY;
                idx_next = idx_reg + 1'b1;
                if (last) state_next = S_Y_RUN;
            end
            S_Y_RUN:
            begin
                cmd.op = OP_RUN_SCHED; state_next = S_OUT;
            end
            S_E_ZOMB:
            begin
                cmd.op = OP_ZOMBIE; state_next = S_E_SCANW;
            end
            S_E_SCANW:
            begin
                cmd.op = OP_SCAN; cmd.kind = SCAN_WAITER;
                idx_next = idx_reg + 1'b1;
                if (last) state_next = S_E_WAKE;
            end
            S_E_WAKE:
            begin
                cmd.op = OP_WAKE; state_next = S_R_SCAN;
            end
            S_R_SCAN:
            begin
                cmd.op = OP_SCAN; cmd.kind = SCAN_READY;
                idx_next = idx_reg + 1'b1;
                if (last) state_next = S_R_RUN;
            end
            S_R_RUN:
            begin
                cmd.op = OP_RUN; state_next = S_OUT;
            end
            S_W_SCANZ:
            begin
                cmd.op = OP_SCAN; cmd.kind = SCAN_ZOMBIE;
                idx_next = idx_reg + 1'b1;
                if (last) state_next = S_W_DECIDE;
            end
            S_W_DECIDE:
            begin
                if (sts.found)
                begin
                    cmd.op = OP_REAP; state_next = S_OUT;
                end
                else if (sts.no_hang)
                begin
                    cmd.op = OP_SETRC; cmd.rc = RC_NOTHING; state_next = S_OUT;
                end
                else
                begin
                    cmd.op = OP_BLOCK; state_next = S_R_SCAN;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== hdl/pts_datapath.sv =====
// ----------------------------------------------------------------------------
// pts_datapath
// Task table, scan unit, running-task copy and output register.
// ----------------------------------------------------------------------------
module pts_datapath
    import pts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [39:0] s_tdata,
    output logic [55:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  pts_cmd_t    cmd,
    output pts_sts_t    sts
);

    logic [2:0]  slot_state_reg    [MAX_TASKS];
    logic [14:0] slot_pid_reg      [MAX_TASKS];
    logic [15:0] slot_parent_reg   [MAX_TASKS];
    logic [7:0]  slot_priority_reg [MAX_TASKS];
    logic [7:0]  slot_exit_reg     [MAX_TASKS];
    logic [15:0] slot_wait_reg     [MAX_TASKS];
    logic [31:0] slot_stamp_reg    [MAX_TASKS];

    logic [IDX_W-1:0] cur_reg;
    logic [14:0]      cur_pid_reg;
    logic [15:0]      cur_parent_reg;
    logic             stalled_reg;
    logic [14:0]      npc_reg;
    logic [31:0]      stamp_reg;

    logic [1:0]  action_reg;
    logic [7:0]  prio_reg;
    logic [7:0]  code_reg;
    logic [15:0] target_reg;
    logic        no_hang_reg;

    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [7:0]       best_prio_reg;
    logic [31:0]      best_age_reg;
    logic [14:0]      best_pid_reg;
    logic [15:0]      best_parent_reg;
    logic [7:0]       best_exit_reg;

    logic [2:0]  rc_reg;
    logic [14:0] rpid_reg;
    logic [15:0] word_reg;
    logic        sw_reg;

    logic        out_valid_reg;
    logic [55:0] out_data_reg;

    logic [2:0]  st_i;
    logic [14:0] pid_i;
    logic [15:0] parent_i;
    logic [7:0]  prio_i;
    logic [15:0] wt_i;
    logic [31:0] age_i;
    logic        have;
    logic        older;
    logic        match;
    logic        take;

    always_comb
    begin
        st_i     = slot_state_reg[cmd.idx];
        pid_i    = slot_pid_reg[cmd.idx];
        parent_i = slot_parent_reg[cmd.idx];
        prio_i   = slot_priority_reg[cmd.idx];
        wt_i     = slot_wait_reg[cmd.idx];
        age_i    = stamp_reg - slot_stamp_reg[cmd.idx];
        have     = found_reg && (cmd.idx != '0);
        older    = age_i > best_age_reg;
        match    = 1'b0;
        case (cmd.kind)
            SCAN_FREE:
                match = (st_i == ST_FREE) && !have;
            SCAN_READY:
                match = (st_i == ST_READY) && (!have ||
                        ($signed(prio_i) > $signed(best_prio_reg)) ||
                        ((prio_i == best_prio_reg) && older));
            SCAN_WAITER:
                match = (st_i == ST_WAITING) && (!have || older) &&
                        ((!wt_i[15] && (wt_i != 16'd0) && (wt_i == {1'b0, cur_pid_reg})) ||
                         ((wt_i == 16'hffff) && ({1'b0, pid_i} == cur_parent_reg)));
            default:
                match = (st_i == ST_ZOMBIE) && (cmd.idx != cur_reg) && (!have || older) &&
                        ((target_reg == 16'hffff) ? (parent_i == {1'b0, cur_pid_reg})
                                                  : ({1'b0, pid_i} == target_reg));
        endcase
        take = (cmd.op == OP_SCAN) && match;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ZOMBIE)
            slot_exit_reg[cur_reg] <= code_reg;
        if (cmd.op == OP_BLOCK)
            slot_wait_reg[cur_reg] <= target_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg  <= s_tdata[1:0];
            prio_reg    <= s_tdata[9:2];
            code_reg    <= s_tdata[17:10];
            target_reg  <= s_tdata[33:18];
            no_hang_reg <= s_tdata[34];
        end
        if (take)
        begin
            found_idx_reg   <= cmd.idx;
            best_prio_reg   <= prio_i;
            best_age_reg    <= age_i;
            best_pid_reg    <= pid_i;
            best_parent_reg <= parent_i;
            best_exit_reg   <= slot_exit_reg[cmd.idx];
        end
        if (cmd.out_load)
            out_data_reg <= {6'd0, sw_reg, cur_pid_reg, word_reg, rpid_reg, rc_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_state_reg[i]    <= ST_FREE;
                slot_pid_reg[i]      <= '0;
                slot_parent_reg[i]   <= '0;
                slot_priority_reg[i] <= '0;
                slot_stamp_reg[i]    <= '0;
            end
            slot_state_reg[0]  <= ST_RUNNING;
            slot_parent_reg[0] <= 16'hffff;
            cur_reg        <= '0;
            cur_pid_reg    <= '0;
            cur_parent_reg <= 16'hffff;
            stalled_reg    <= 1'b0;
            npc_reg        <= 15'd1;
            stamp_reg      <= '0;
            found_reg      <= 1'b0;
            rc_reg         <= RC_OK;
            rpid_reg       <= '0;
            word_reg       <= '0;
            sw_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cmd.latch)
            begin
                rc_reg   <= RC_OK;
                rpid_reg <= '0;
                word_reg <= '0;
                sw_reg   <= 1'b0;
            end

            if (cmd.op == OP_SCAN)
                found_reg <= have || match;

            case (cmd.op)
                OP_SETRC: rc_reg <= cmd.rc;
                OP_CREATE:
                begin
                    if (!found_reg)
                        rc_reg <= RC_FULL;
                    else
                    begin
                        slot_pid_reg[found_idx_reg]      <= npc_reg;
                        slot_parent_reg[found_idx_reg]   <= {1'b0, cur_pid_reg};
                        slot_priority_reg[found_idx_reg] <= prio_reg;
                        slot_state_reg[found_idx_reg]    <= ST_READY;
                        slot_stamp_reg[found_idx_reg]    <= stamp_reg;
                        stamp_reg <= stamp_reg + 32'd1;
                        rpid_reg  <= npc_reg;
                        npc_reg   <= (npc_reg == PID_MAX) ? 15'd1 : npc_reg + 15'd1;
                    end
                end
                OP_RUN, OP_RUN_SCHED:
                begin
                    if (found_reg)
                    begin
                        if (!stalled_reg)
                        begin
                            slot_state_reg[cur_reg] <= ST_READY;
                            slot_stamp_reg[cur_reg] <= stamp_reg;
                            stamp_reg <= stamp_reg + 32'd1;
                        end
                        slot_state_reg[found_idx_reg] <= ST_RUNNING;
                        cur_reg        <= found_idx_reg;
                        cur_pid_reg    <= best_pid_reg;
                        cur_parent_reg <= best_parent_reg;
                        stalled_reg    <= 1'b0;
                        sw_reg         <= 1'b1;
                    end
                    else if (cmd.op == OP_RUN_SCHED)
                        rc_reg <= RC_NOTHING;
                end
                OP_ZOMBIE:
                begin
                    slot_state_reg[cur_reg] <= ST_ZOMBIE;
                    slot_stamp_reg[cur_reg] <= stamp_reg;
                    stamp_reg   <= stamp_reg + 32'd1;
                    stalled_reg <= 1'b1;
                end
                OP_WAKE:
                begin
                    if (found_reg)
                    begin
                        slot_state_reg[found_idx_reg] <= ST_READY;
                        slot_stamp_reg[found_idx_reg] <= stamp_reg;
                        stamp_reg <= stamp_reg + 32'd1;
                    end
                end
                OP_REAP:
                begin
                    slot_state_reg[found_idx_reg] <= ST_FREE;
                    rpid_reg <= best_pid_reg;
                    word_reg <= {best_exit_reg, 8'h00};
                end
                OP_BLOCK:
                begin
                    slot_state_reg[cur_reg] <= ST_WAITING;
                    slot_stamp_reg[cur_reg] <= stamp_reg;
                    stamp_reg   <= stamp_reg + 32'd1;
                    stalled_reg <= 1'b1;
                    rc_reg      <= RC_BLOCKED;
                end
                default: ;
            endcase
        end
    end

    assign sts.action     = action_reg;
    assign sts.stalled    = stalled_reg;
    assign sts.kernel     = (cur_pid_reg == 15'd0);
    assign sts.target_bad = target_reg[15] && (target_reg != 16'hffff);
    assign sts.no_hang    = no_hang_reg;
    assign sts.found      = found_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hdl/priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Priority ready-queue task scheduler, FIFO order within a priority.
//
//   channel   dir  fields (tdata, lsb first)
//   s_axis    in   action, priority_req, exit_code, target_pid, no_hang
//   m_axis    out  result_code, returned_pid, exit_word, running_pid, switched
//
// Each table scan visits every slot, one slot per cycle. Create and schedule
// run one scan; an exit that proceeds runs two; a wait that proceeds runs one,
// or two when the caller blocks. The output register frees the sequencer once loaded.
// Reset is asynchronous; the table is usable as soon as reset is released.
// A stalled output holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module priority_task_scheduler
    import pts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action, priority_req, exit_code, target_pid, no_hang
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // result_code, returned_pid, exit_word, running_pid, switched
);

    pts_cmd_t cmd;
    pts_sts_t sts;

    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pts_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ===== sim/tb_priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler
// Self-checking testbench of the priority task scheduler. A cycle-free model
// of the task table predicts one result per accepted command. Directed
// commands cover the corner cases, then random command streams run under
// several source-idle and sink-stall phases.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler;
    import pts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic        sw;
        logic [14:0] run_pid;
        logic [15:0] word;
        logic [14:0] rpid;
        logic [2:0]  rc;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    logic        s_acc = 1'b0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          errors = 0;
    int          idle_cycles = 0;

    sched_result_t result_q[$];

    // task table model
    logic [2:0]         t_state [MAX_TASKS];
    logic [14:0]        t_pid   [MAX_TASKS];
    int                 t_parent[MAX_TASKS];
    logic signed [7:0]  t_prio  [MAX_TASKS];
    logic [7:0]         t_code  [MAX_TASKS];
    int                 t_target[MAX_TASKS];
    logic [31:0]        t_stamp [MAX_TASKS];
    int                 cur_slot;
    logic [14:0]        pid_ctr;
    logic [31:0]        stamp_cnt;

    priority_task_scheduler u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk) s_acc <= s_tvalid && s_tready;

    always @(negedge clk)
        if (rst_n)
            m_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t exp_r;
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $realtime, WDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[49:0];
            if (result_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $realtime, got);
                errors++;
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (got.rc !== exp_r.rc)
                    $display("%0t result_code: expected %0d, actual %0d",
                             $realtime, exp_r.rc, got.rc);
                if (got.rpid !== exp_r.rpid)
                    $display("%0t returned_pid: expected %0d, actual %0d",
                             $realtime, exp_r.rpid, got.rpid);
                if (got.word !== exp_r.word)
                    $display("%0t exit_word: expected %h, actual %h",
                             $realtime, exp_r.word, got.word);
                if (got.run_pid !== exp_r.run_pid)
                    $display("%0t running_pid: expected %0d, actual %0d",
                             $realtime, exp_r.run_pid, got.run_pid);
                if (got.sw !== exp_r.sw)
                    $display("%0t switched: expected %0d, actual %0d",
                             $realtime, exp_r.sw, got.sw);
                if (got !== exp_r)
                    errors++;
            end
        end
    end

    function automatic logic [31:0] age(int s);
        return stamp_cnt - t_stamp[s];
    endfunction

    function automatic void stamp(int s);
        t_stamp[s] = stamp_cnt;
        stamp_cnt  = stamp_cnt + 1;
    endfunction

    function automatic int best_ready();
        int b;
        b = -1;
        for (int i = 0; i < MAX_TASKS; i++)
            if (t_state[i] == ST_READY &&
                (b < 0 || t_prio[i] > t_prio[b] ||
                 (t_prio[i] == t_prio[b] && age(i) > age(b))))
                b = i;
        return b;
    endfunction

    function automatic logic dispatch();
        int n;
        n = best_ready();
        if (n < 0)
            return 1'b0;
        if (t_state[cur_slot] == ST_RUNNING)
        begin
            t_state[cur_slot] = ST_READY;
            stamp(cur_slot);
        end
        t_state[n] = ST_RUNNING;
        cur_slot   = n;
        return 1'b1;
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            t_state[i]  = ST_FREE;
            t_pid[i]    = '0;
            t_parent[i] = 0;
            t_prio[i]   = '0;
            t_code[i]   = '0;
            t_target[i] = 0;
            t_stamp[i]  = '0;
        end
        t_state[0]  = ST_RUNNING;
        t_parent[0] = -1;
        cur_slot    = 0;
        pid_ctr     = 15'd1;
        stamp_cnt   = '0;
    endfunction

    function automatic sched_result_t next_state(logic [1:0] act, logic signed [7:0] prio,
                                                 logic [7:0] code, logic signed [15:0] tgt,
                                                 logic nh);
        sched_result_t r;
        int     f;
        int     c;
        int     target;
        logic   stalled;
        logic   m;
        r       = '0;
        c       = cur_slot;
        target  = tgt;
        stalled = (t_state[c] != ST_RUNNING);
        if (act == ACT_CREATE)
        begin
            f = -1;
            for (int i = 0; i < MAX_TASKS; i++)
                if (f < 0 && t_state[i] == ST_FREE)
                    f = i;
            if (f < 0)
                r.rc = RC_FULL;
            else
            begin
                t_pid[f]    = pid_ctr;
                t_parent[f] = t_pid[c];
                t_prio[f]   = prio;
                t_state[f]  = ST_READY;
                stamp(f);
                r.rpid  = pid_ctr;
                pid_ctr = (pid_ctr == PID_MAX) ? 15'd1 : pid_ctr + 15'd1;
            end
        end
        else if (act == ACT_SCHED)
        begin
            r.sw = dispatch();
            r.rc = r.sw ? RC_OK : RC_NOTHING;
        end
        else if (act == ACT_EXIT)
        begin
            if (t_pid[c] == 0)
                r.rc = RC_KERNEL;
            else if (stalled)
                r.rc = RC_NOTHING;
            else
            begin
                t_state[c] = ST_ZOMBIE;
                t_code[c]  = code;
                stamp(c);
                f = -1;
                for (int i = 0; i < MAX_TASKS; i++)
                    if (t_state[i] == ST_WAITING)
                    begin
                        m = (t_target[i] > 0 && t_target[i] == int'(t_pid[c])) ||
                            (t_target[i] == -1 && int'(t_pid[i]) == t_parent[c]);
                        if (m && (f < 0 || age(i) > age(f)))
                            f = i;
                    end
                if (f >= 0)
                begin
                    t_state[f] = ST_READY;
                    stamp(f);
                end
                r.sw = dispatch();
            end
        end
        else
        begin
            if (target < -1)
                r.rc = RC_UNSUPP;
            else if (stalled)
                r.rc = RC_NOTHING;
            else
            begin
                f = -1;
                for (int i = 0; i < MAX_TASKS; i++)
                    if (t_state[i] == ST_ZOMBIE && i != c)
                    begin
                        m = (target == -1) ? (t_parent[i] == int'(t_pid[c]))
                                           : (int'(t_pid[i]) == target);
                        if (m && (f < 0 || age(i) > age(f)))
                            f = i;
                    end
                if (f >= 0)
                begin
                    r.rpid     = t_pid[f];
                    r.word     = {t_code[f], 8'h00};
                    t_state[f] = ST_FREE;
                end
                else if (nh)
                    r.rc = RC_NOTHING;
                else
                begin
                    t_state[c]  = ST_WAITING;
                    t_target[c] = target;
                    stamp(c);
                    r.sw = dispatch();
                    r.rc = RC_BLOCKED;
                end
            end
        end
        r.run_pid = t_pid[cur_slot];
        return r;
    endfunction

    task automatic send_cmd(logic [1:0] act, logic signed [7:0] prio, logic [7:0] code,
                            logic signed [15:0] tgt, logic nh);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, nh, tgt, code, prio, act};
        forever
        begin
            @(negedge clk);
            if (s_acc)
                break;
        end
        result_q.push_back(next_state(act, prio, code, tgt, nh));
    endtask

    function automatic logic signed [15:0] pick_target();
        int s;
        case ($urandom_range(9))
            0, 1, 2, 3: return -16'sd1;
            4:          return 16'sd0;
            5:          return 16'($urandom);
            default:
            begin
                s = $urandom_range(MAX_TASKS - 1);
                return {1'b0, t_pid[s]};
            end
        endcase
    endfunction

    task automatic test_directed();
        send_cmd(ACT_EXIT, 8'sd0, 8'hff, -16'sd1, 1'b0);
        send_cmd(ACT_WAIT, 8'sd0, 8'h00, -16'sd2, 1'b0);
        send_cmd(ACT_WAIT, 8'sd0, 8'h00, 16'sh8000, 1'b1);
        send_cmd(ACT_WAIT, 8'sd0, 8'h00, -16'sd1, 1'b1);
        send_cmd(ACT_SCHED, 8'sd0, 8'h00, 16'sd0, 1'b0);
        send_cmd(ACT_CREATE, 8'sd127, 8'h00, 16'sd0, 1'b0);
        send_cmd(ACT_CREATE, -8'sd128, 8'h00, 16'sd0, 1'b0);
        for (int i = 0; i < 13; i++)
            send_cmd(ACT_CREATE, 8'sd5, 8'h00, 16'sd0, 1'b0);
        send_cmd(ACT_CREATE, 8'sd1, 8'h00, 16'sd0, 1'b0);
        send_cmd(ACT_SCHED, 8'sd0, 8'h00, 16'sd0, 1'b0);
        send_cmd(ACT_WAIT, 8'sd0, 8'h00, 16'sd0, 1'b0);
        send_cmd(ACT_EXIT, 8'sd0, 8'hab, 16'sd0, 1'b0);
        send_cmd(ACT_WAIT, 8'sd0, 8'h00, 16'sd3, 1'b1);
        send_cmd(ACT_WAIT, 8'sd0, 8'h00, 16'h7fff, 1'b0);
    endtask

    task automatic test_random(int n);
        int                a;
        logic signed [7:0] prio;
        for (int k = 0; k < n; k++)
        begin
            a    = $urandom_range(99);
            prio = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            if (a < 30)
                send_cmd(ACT_CREATE, prio, 8'($urandom), pick_target(), 1'($urandom));
            else if (a < 55)
                send_cmd(ACT_SCHED, prio, 8'($urandom), pick_target(), 1'($urandom));
            else if (a < 75)
                send_cmd(ACT_EXIT, prio, 8'($urandom), pick_target(), 1'($urandom));
            else
                send_cmd(ACT_WAIT, prio, 8'($urandom),
                         ($urandom_range(19) == 0) ? 16'($urandom) : pick_target(),
                         ($urandom_range(2) == 0));
        end
    endtask

    initial
    begin
        table_reset();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(150);
        src_idle_pct = 79;
        test_random(150);
        src_idle_pct  = 0;
        snk_stall_pct = 79;
        test_random(150);
        src_idle_pct  = 10;
        snk_stall_pct = 10;
        test_random(150);
        s_tvalid = 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
